// ----- src/load_switch_sense_and_fault_unit_assert.svh -----
// ----------------------------------------------------------------------------
// load switch supervisor assertion macros
// shared property forms for the unit's concurrent checks
// ----------------------------------------------------------------------------
`ifndef LOAD_SWITCH_SENSE_AND_FAULT_UNIT_ASSERT_SVH
`define LOAD_SWITCH_SENSE_AND_FAULT_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSSF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LSSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lssf_pkg.sv -----
// ----------------------------------------------------------------------------
// lssf_pkg
// shared types and codes of the load switch supervisor
// ----------------------------------------------------------------------------
package lssf_pkg;

    localparam int MV_W   = 16;
    localparam int CUR_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int PROD_W = 2 * MV_W;

    // opcodes of an input word
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_ENABLE  = 2'd2;
    localparam logic [1:0] OP_DISABLE = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FAULT   = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_FAULT_THR  = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEAK_THR   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN       = 3'd2;
    localparam logic [IDX_W-1:0] REG_RESISTOR   = 3'd3;
    localparam logic [IDX_W-1:0] REG_BIAS       = 3'd4;
    localparam logic [IDX_W-1:0] REG_RESTART    = 3'd5;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [MV_W-1:0] sense_mv;
    } req_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CUR_W-1:0] current_value;
        logic             output_on;
        logic             fault_active;
    } rsp_word_t;

endpackage

// ----- src/lssf_mul.sv -----
// ----------------------------------------------------------------------------
// lssf_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module lssf_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lssf_pkg::MV_W-1:0]       mcand,
    input  logic [lssf_pkg::MV_W-1:0]       mplier,
    output logic                            done,
    output logic [lssf_pkg::PROD_W-1:0]     product
);

    localparam int W = lssf_pkg::MV_W;

    logic [2*W:0]         p_reg;
    logic [2*W:0]         p_next;
    logic [W-1:0]         mcand_reg;
    logic [$clog2(W)-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [W:0]           upper_sum;

    // add the multiplicand into the upper half when the low bit is set
    always_comb
    begin
        if (p_reg[0])
        begin
            upper_sum = {1'b0, p_reg[2*W-1:W]} + {1'b0, mcand_reg};
        end
        else
        begin
            upper_sum = {1'b0, p_reg[2*W-1:W]};
        end
        p_next = {1'b0, upper_sum, p_reg[W-1:1]};
    end

    // control: counts W steps after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == $clog2(W)'(W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == $clog2(W)'(W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg     <= {{(W + 1){1'b0}}, mplier};
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

    assign done    = done_reg;
    assign product = p_reg[2*W-1:0];

endmodule

// ----- src/lssf_div.sv -----
// ----------------------------------------------------------------------------
// lssf_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lssf_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lssf_pkg::PROD_W-1:0]     dividend,
    input  logic [lssf_pkg::MV_W-1:0]       divisor,
    output logic                            done,
    output logic [lssf_pkg::PROD_W-1:0]     quotient
);

    localparam int QW = lssf_pkg::PROD_W;
    localparam int DW = lssf_pkg::MV_W;

    logic [QW-1:0]         q_reg;
    logic [DW-1:0]         r_reg;
    logic [DW-1:0]         d_reg;
    logic [$clog2(QW)-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DW:0]           trial;
    logic [DW+1:0]         diff;
    logic                  q_bit;
    logic [DW-1:0]         r_next;

    // shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial = {r_reg, q_reg[QW-1]};
        diff  = {1'b0, trial} - {2'b00, d_reg};
        q_bit = ~diff[DW+1];
        if (q_bit)
        begin
            r_next = diff[DW-1:0];
        end
        else
        begin
            r_next = trial[DW-1:0];
        end
    end

    // control: counts QW steps after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == $clog2(QW)'(QW - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == $clog2(QW)'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath, divisor of zero treated as one
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= (divisor == '0) ? DW'(1) : divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[QW-2:0], q_bit};
            r_reg <= r_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- src/load_switch_sense_and_fault_unit.sv -----
// ----------------------------------------------------------------------------
// load_switch_sense_and_fault_unit
// load switch supervisor: fault detection, restart timing, current readout
// ----------------------------------------------------------------------------
// Takes one word at a time and returns exactly one result word for each.
// Ticks, enable and disable requests, fault samples and samples at or below
// the leakage threshold go from the accept straight to the output register
// write. A sample that needs conversion passes from the accept through the
// bit-serial multiplier for sense_mv * sense_gain, a handoff to the radix-2
// divider for the 32-bit product over sense_resistor, then the capture of the
// clamped current and the output write. Every output write waits while an
// untaken result holds the output register. A new word is accepted as soon as
// the previous one sits in the output register, even if that result has not yet been taken.
module load_switch_sense_and_fault_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  lssf_pkg::req_word_t                req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output lssf_pkg::rsp_word_t                rsp,
    input  logic                               cfg_we,
    input  logic [lssf_pkg::IDX_W-1:0]         cfg_index,
    input  logic [lssf_pkg::CFG_W-1:0]         cfg_data
);

    localparam int W  = lssf_pkg::MV_W;
    localparam int PW = lssf_pkg::PROD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    // configuration registers
    logic [W-1:0]        fault_thr_reg;
    logic [W-1:0]        leak_thr_reg;
    logic [W-1:0]        gain_reg;
    logic [W-1:0]        resistor_reg;
    logic signed [W-1:0] bias_reg;
    logic [W-1:0]        restart_reg;

    // supervisor state
    logic         enable_reg,  enable_next;
    logic         fault_reg,   fault_next;
    logic         restore_reg, restore_next;
    logic [W-1:0] count_reg,   count_next;

    logic [1:0]   state_reg;
    logic [1:0]   status_reg,  status_next;
    logic [lssf_pkg::CUR_W-1:0] cur_reg;
    logic         conv_needed;

    logic                 rsp_valid_reg;
    lssf_pkg::rsp_word_t  rsp_reg;

    logic                 accept;
    logic                 mul_done;
    logic [PW-1:0]        product;
    logic                 div_done;
    logic [PW-1:0]        quotient;
    logic signed [PW+1:0] biased;
    logic [lssf_pkg::CUR_W-1:0] cur_clamped;
    logic                 wb_fire;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign wb_fire   = (state_reg == ST_WB) && (!rsp_valid_reg || rsp_ready);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_thr_reg <= '1;
            leak_thr_reg  <= '0;
            gain_reg      <= W'(1);
            resistor_reg  <= W'(1);
            bias_reg      <= '0;
            restart_reg   <= W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lssf_pkg::REG_FAULT_THR: fault_thr_reg <= cfg_data;
                lssf_pkg::REG_LEAK_THR:  leak_thr_reg  <= cfg_data;
                lssf_pkg::REG_GAIN:      gain_reg      <= cfg_data;
                lssf_pkg::REG_RESISTOR:  resistor_reg  <= cfg_data;
                lssf_pkg::REG_BIAS:      bias_reg      <= $signed(cfg_data);
                lssf_pkg::REG_RESTART:   restart_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // decode of an accepted word and its effect on the supervisor state
    always_comb
    begin
        enable_next  = enable_reg;
        fault_next   = fault_reg;
        restore_next = restore_reg;
        count_next   = count_reg;
        status_next  = lssf_pkg::STAT_OK;
        conv_needed  = 1'b0;
        case (req.opcode)
            lssf_pkg::OP_SAMPLE:
            begin
                if (req.sense_mv >= fault_thr_reg)
                begin
                    status_next = lssf_pkg::STAT_FAULT;
                    if (!fault_reg)
                    begin
                        fault_next   = 1'b1;
                        count_next   = restart_reg;
                        restore_next = enable_reg;
                        enable_next  = 1'b0;
                    end
                end
                else if (req.sense_mv > leak_thr_reg)
                begin
                    conv_needed = 1'b1;
                end
            end
            lssf_pkg::OP_TICK:
            begin
                if (fault_reg)
                begin
                    if (count_reg <= W'(1))
                    begin
                        count_next   = '0;
                        fault_next   = 1'b0;
                        enable_next  = enable_reg | restore_reg;
                        restore_next = 1'b0;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            lssf_pkg::OP_ENABLE:
            begin
                if (fault_reg)
                begin
                    status_next = lssf_pkg::STAT_REFUSED;
                end
                else
                begin
                    enable_next = 1'b1;
                end
            end
            lssf_pkg::OP_DISABLE:
            begin
                enable_next  = 1'b0;
                restore_next = 1'b0;
            end
            default: ;
        endcase
    end

    // quotient minus bias, clamped to the output range
    always_comb
    begin
        biased = $signed({2'b00, quotient}) - (PW + 2)'(bias_reg);
        if (biased[PW+1])
        begin
            cur_clamped = '0;
        end
        else if (biased[PW:lssf_pkg::CUR_W] != '0)
        begin
            cur_clamped = '1;
        end
        else
        begin
            cur_clamped = biased[lssf_pkg::CUR_W-1:0];
        end
    end

    lssf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && conv_needed),
        .mcand   (gain_reg),
        .mplier  (req.sense_mv),
        .done    (mul_done),
        .product (product)
    );

    lssf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((state_reg == ST_MUL) && mul_done),
        .dividend (product),
        .divisor  (resistor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // sequencer and supervisor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            enable_reg  <= 1'b0;
            fault_reg   <= 1'b0;
            restore_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        enable_reg  <= enable_next;
                        fault_reg   <= fault_next;
                        restore_reg <= restore_next;
                        count_reg   <= count_next;
                        state_reg   <= conv_needed ? ST_MUL : ST_WB;
                    end
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_WB;
                    end
                end
                ST_WB:
                begin
                    if (wb_fire)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result fields held until write-back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            cur_reg    <= '0;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            cur_reg <= cur_clamped;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (wb_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_fire)
        begin
            rsp_reg.status        <= status_reg;
            rsp_reg.current_value <= cur_reg;
            rsp_reg.output_on     <= enable_reg;
            rsp_reg.fault_active  <= fault_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `include "load_switch_sense_and_fault_unit_assert.svh"

    `LSSF_ASSERT_NOW(a_restore_only_in_fault, restore_reg, fault_reg, "restore pending without fault")
    `LSSF_ASSERT_NOW(a_restore_means_off, restore_reg, !enable_reg, "restore pending while output on")
    `LSSF_ASSERT_NEXT(a_mul_to_div, (state_reg == ST_MUL) && mul_done, state_reg == ST_DIV, "multiply did not hand off")
    `LSSF_ASSERT_NOW(a_current_only_ok, rsp_valid && (rsp.status != lssf_pkg::STAT_OK), rsp.current_value == '0, "current on non-ok result")

endmodule
